// ----- rtl/grc_pkg.sv -----
// ============================================================================
// Grid ray-cast wall column: shared package
// Types, constants and register indexes used across the ray-cast block.
// ============================================================================
package grc_pkg;

   // Widths of the shared iterative divider.
   localparam int DIV_NUM_W = 33;
   localparam int DIV_DEN_W = 25;

   // Configuration port geometry.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 21;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_POS_X       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POS_Y       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_VIEW_DIR_X  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_VIEW_DIR_Y  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAM_PLANE_X = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAM_PLANE_Y = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_SIZE   = 3'd6;

   // Distance clamp and fog slope, Q16.
   localparam logic [23:0] DIST_MIN = 24'd3277;
   localparam logic [23:0] DIST_MAX = 24'hFFFFFF;
   localparam logic [13:0] FOG_COEF = 14'd11796;

   // Request kinds after classification.
   typedef enum logic {
      OP_WRITE,
      OP_CAST
   } op_type;

   // One queued request.
   typedef struct packed {
      op_type      op;
      logic [4:0]  row;
      logic [4:0]  col;
      logic [2:0]  value;
      logic [8:0]  column;
   } entry_type;

   // Configuration as seen by the back end.
   typedef struct packed {
      logic [20:0] pos_x;
      logic [20:0] pos_y;
      logic [17:0] view_dir_x;
      logic [17:0] view_dir_y;
      logic [17:0] cam_plane_x;
      logic [17:0] cam_plane_y;
      logic [4:0]  grid_size;
   } cfg_type;

   // Divider command and answer.
   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ----- rtl/grc_if.sv -----
// ============================================================================
// Grid ray-cast wall column: channel interfaces
// Valid/ready request and result channels with their payload fields.
// ============================================================================
interface grc_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [4:0] cell_row;
   logic [4:0] cell_col;
   logic [2:0] cell_value;
   logic [8:0] screen_column;

   modport source (output valid, cmd, cell_row, cell_col, cell_value, screen_column,
                   input ready);
   modport sink   (input valid, cmd, cell_row, cell_col, cell_value, screen_column,
                   output ready);
endinterface

interface grc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  wall_texture;
   logic        hit_side;
   logic [23:0] wall_distance;
   logic [6:0]  wall_top;
   logic [7:0]  wall_bottom;
   logic [5:0]  tex_column;
   logic [21:0] tex_row_start;
   logic [22:0] tex_row_step;
   logic [8:0]  fog_factor;

   modport source (output valid, wall_texture, hit_side, wall_distance, wall_top,
                   wall_bottom, tex_column, tex_row_start, tex_row_step, fog_factor,
                   input ready);
   modport sink   (input valid, wall_texture, hit_side, wall_distance, wall_top,
                   wall_bottom, tex_column, tex_row_start, tex_row_step, fog_factor,
                   output ready);
endinterface

// ----- rtl/grc_div.sv -----
// ============================================================================
// Grid ray-cast wall column: iterative divider
// Unsigned restoring divider, one quotient bit per cycle, shared by all the
// divisions of a cast.
// ============================================================================
module grc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  grc_pkg::div_req_type div_req,
   output grc_pkg::div_rsp_type div_rsp
);
   import grc_pkg::*;

   localparam int CNT_W = $clog2(DIV_NUM_W + 1);

   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_DEN_W:0]   trial;
   logic [DIV_DEN_W:0]   diff;
   logic                 fits;

   // One restoring step on the current partial remainder.
   always_comb begin
      trial = {rem_ff, num_ff[DIV_NUM_W-1]};
      diff  = trial - {1'b0, den_ff};
      fits  = trial >= {1'b0, den_ff};
      rem_in  = rem_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = '0;
         num_in  = div_req.dividend;
         den_in  = div_req.divisor;
         cnt_in  = CNT_W'(DIV_NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
         num_in = {num_ff[DIV_NUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = num_ff;

endmodule

// ----- rtl/grc_front.sv -----
// ============================================================================
// Grid ray-cast wall column: front end
// Accepts requests, drops map writes outside the store, clamps the screen
// column, and queues the rest in a two-entry FIFO for the back end.
// ============================================================================
module grc_front #(
   parameter int MAP_DIM      = 32,
   parameter int SCREEN_WIDTH = 320
) (
   input  logic                clock,
   input  logic                reset,
   grc_req_if.sink             req_bus,
   output logic                q_valid,
   output grc_pkg::entry_type  q_entry,
   input  logic                q_pop
);
   import grc_pkg::*;

   entry_type   fifo_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        accept;
   logic        keep;
   logic        push;
   entry_type   entry_new;

   assign req_bus.ready = (count_ff != 2'd2);
   assign accept        = req_bus.valid && req_bus.ready;

   // Classify the incoming request.
   always_comb begin
      keep = req_bus.cmd ||
             ((7'(req_bus.cell_row) < 7'(MAP_DIM)) && (7'(req_bus.cell_col) < 7'(MAP_DIM)));
      entry_new.op    = req_bus.cmd ? OP_CAST : OP_WRITE;
      entry_new.row   = req_bus.cell_row;
      entry_new.col   = req_bus.cell_col;
      entry_new.value = req_bus.cell_value;
      entry_new.column = (11'(req_bus.screen_column) >= 11'(SCREEN_WIDTH)) ?
                         9'(SCREEN_WIDTH - 1) : req_bus.screen_column;
   end

   assign push = accept && keep;

   // Queue pointers and fill level.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         fifo_ff[wr_ptr_ff] <= entry_new;
      end
   end

   assign q_valid = (count_ff != 2'd0);
   assign q_entry = fifo_ff[rd_ptr_ff];

endmodule

// ----- rtl/grc_back.sv -----
// ============================================================================
// Grid ray-cast wall column: back end
// Holds the map store and runs one queued request at a time: map writes
// straight from idle, casts through ray setup, the DDA walk, projection and fog.
// ============================================================================
module grc_back #(
   parameter int MAP_DIM       = 32,
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 200,
   parameter int TEXTURE_SIZE  = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  grc_pkg::entry_type    q_entry,
   output logic                  q_pop,
   input  grc_pkg::cfg_type      cfg,
   output grc_pkg::div_req_type  div_req,
   input  grc_pkg::div_rsp_type  div_rsp,
   grc_rsp_if.source             rsp_bus
);
   import grc_pkg::*;

   localparam int ADDR_W = $clog2(MAP_DIM * MAP_DIM);
   localparam int HALF_H = SCREEN_HEIGHT / 2;
   // Reciprocal of the screen width scaled by 2^37; col * CAM_RECIP >> 20
   // equals floor(col * 2^17 / SCREEN_WIDTH) for every column in range.
   localparam longint CAM_RECIP = ((longint'(1) <<< 37) + longint'(SCREEN_WIDTH) - 1) /
                                  longint'(SCREEN_WIDTH);

   typedef enum logic [4:0] {
      S_IDLE, S_CAM, S_RAY_X, S_RAY_Y,
      S_DDX_GO, S_DDX_WAIT, S_DDY_GO, S_DDY_WAIT, S_SIDE,
      S_WALK, S_READ, S_DIST, S_LH_GO, S_LH_WAIT,
      S_TSTEP_GO, S_TSTEP_WAIT, S_TEXROW, S_FOG_GO, S_FOG_WAIT, S_OUT
   } state_type;

   state_type           state_ff, state_in;
   logic [8:0]          col_ff, col_in;
   logic signed [17:0]  cam_ff, cam_in;
   logic signed [19:0]  rdx_ff, rdx_in, rdy_ff, rdy_in;
   logic [40:0]         ddx_ff, ddx_in, ddy_ff, ddy_in;
   logic [47:0]         sdx_ff, sdx_in, sdy_ff, sdy_in;
   logic signed [6:0]   mx_ff, mx_in, my_ff, my_in;
   logic                side_ff, side_in;
   logic                exit_ff, exit_in;
   logic [2:0]          code_ff, code_in;
   logic [23:0]         dist_ff, dist_in;
   logic [14:0]         lh_ff, lh_in;
   logic [24:0]         tstep_ff, tstep_in;
   logic [22:0]         fog_den_ff, fog_den_in;
   logic [15:0]         wfrac_ff, wfrac_in;
   logic [8:0]          fog_ff, fog_in;
   logic [21:0]         ty_ff, ty_in;
   logic [6:0]          top_ff, top_in;
   logic [7:0]          bot_ff, bot_in;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          o_tex_ff, o_tex_in;
   logic                o_side_ff, o_side_in;
   logic [23:0]         o_dist_ff, o_dist_in;
   logic [6:0]          o_top_ff, o_top_in;
   logic [7:0]          o_bot_ff, o_bot_in;
   logic [5:0]          o_txc_ff, o_txc_in;
   logic [21:0]         o_ty_ff, o_ty_in;
   logic [22:0]         o_step_ff, o_step_in;
   logic [8:0]          o_fog_ff, o_fog_in;

   // Map store.
   logic [2:0]          map_mem [MAP_DIM * MAP_DIM];
   logic [2:0]          rdata_ff;
   logic                mem_we;
   logic [ADDR_W-1:0]   wr_addr;
   logic [ADDR_W-1:0]   rd_addr;
   logic [12:0]         wr_wide;
   logic [12:0]         rd_wide;
   logic [5:0]          rd_row;
   logic [5:0]          rd_col;

   // Walk helpers.
   logic                x_first;
   logic signed [6:0]   nmx, nmy;
   logic [6:0]          lim;
   logic                leave;

   // Arithmetic helpers.
   logic [47:0]         cam_prod;
   logic signed [35:0]  plane_prod;
   logic [18:0]         abs_x, abs_y;
   logic [16:0]         frac_x, frac_y;
   logic [47:0]         dist_raw;
   logic [37:0]         fog_prod;
   logic signed [19:0]  rd_other;
   logic signed [44:0]  wprod;
   logic [15:0]         half_lh;
   logic [15:0]         hdiff;
   logic [15:0]         bsum;
   logic [38:0]         ty_prod;
   logic [24:0]         tx_prod;
   logic [5:0]          tx_raw;
   logic                mirror;
   logic [10:0]         fog3;

   // Initial side distance: frac times step length, Q16.
   function automatic logic [47:0] side_init(input logic [16:0] f, input logic [40:0] d);
      logic [49:0] full;
      begin
         full = 50'(f) * 50'(d[31:0]) + (d[32] ? {1'b0, f, 32'b0} : 50'b0);
         if (d[40]) begin
            side_init = {7'b0, f, 24'b0};
         end else begin
            side_init = {14'b0, full[49:16]};
         end
      end
   endfunction

   // Map store ports.
   assign wr_wide = 13'(q_entry.row) * 13'(MAP_DIM) + 13'(q_entry.col);
   assign wr_addr = wr_wide[ADDR_W-1:0];
   assign rd_wide = 13'(rd_row) * 13'(MAP_DIM) + 13'(rd_col);
   assign rd_addr = rd_wide[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[wr_addr] <= q_entry.value;
      end
      rdata_ff <= map_mem[rd_addr];
   end

   // One DDA step: advance the nearer side, then test for leaving the map.
   always_comb begin
      x_first = sdx_ff < sdy_ff;
      nmx = mx_ff;
      nmy = my_ff;
      if (x_first) begin
         nmx = mx_ff + (rdx_ff[19] ? 7'sh7F : 7'sh01);
      end else begin
         nmy = my_ff + (rdy_ff[19] ? 7'sh7F : 7'sh01);
      end
      lim = (7'(cfg.grid_size) < 7'(MAP_DIM)) ? 7'(cfg.grid_size) : 7'(MAP_DIM);
      leave = nmx[6] || nmy[6] || (7'(nmx) >= lim) || (7'(nmy) >= lim);
      rd_row = leave ? 6'd0 : nmy[5:0];
      rd_col = leave ? 6'd0 : nmx[5:0];
   end

   // Datapath terms that feed the sequencer.
   always_comb begin
      cam_prod   = 48'(col_ff) * 48'(CAM_RECIP);
      plane_prod = (state_ff == S_RAY_X) ? $signed(cfg.cam_plane_x) * cam_ff
                                         : $signed(cfg.cam_plane_y) * cam_ff;
      abs_x  = rdx_ff[19] ? 19'(-rdx_ff) : rdx_ff[18:0];
      abs_y  = rdy_ff[19] ? 19'(-rdy_ff) : rdy_ff[18:0];
      frac_x = rdx_ff[19] ? {1'b0, cfg.pos_x[15:0]} : 17'h10000 - {1'b0, cfg.pos_x[15:0]};
      frac_y = rdy_ff[19] ? {1'b0, cfg.pos_y[15:0]} : 17'h10000 - {1'b0, cfg.pos_y[15:0]};
      dist_raw = side_ff ? sdy_ff - {7'b0, ddy_ff} : sdx_ff - {7'b0, ddx_ff};
      fog_prod = 38'(dist_ff) * 38'(FOG_COEF);
      rd_other = side_ff ? rdx_ff : rdy_ff;
      wprod    = $signed({1'b0, dist_ff}) * rd_other;
      half_lh  = 16'(lh_ff >> 1);
      hdiff    = half_lh - 16'(HALF_H);
      bsum     = 16'(HALF_H) + half_lh;
      ty_prod  = 39'(hdiff) * 39'(tstep_ff);
      tx_prod  = 25'(wfrac_ff) * 25'(TEXTURE_SIZE);
      tx_raw   = tx_prod[21:16];
      mirror   = (!side_ff && !rdx_ff[19] && (rdx_ff != 20'sd0)) || (side_ff && rdy_ff[19]);
      fog3     = 11'(fog_ff) * 11'd3;
   end

   // Sequencer.
   always_comb begin
      state_in   = state_ff;
      col_in     = col_ff;
      cam_in     = cam_ff;
      rdx_in     = rdx_ff;
      rdy_in     = rdy_ff;
      ddx_in     = ddx_ff;
      ddy_in     = ddy_ff;
      sdx_in     = sdx_ff;
      sdy_in     = sdy_ff;
      mx_in      = mx_ff;
      my_in      = my_ff;
      side_in    = side_ff;
      exit_in    = exit_ff;
      code_in    = code_ff;
      dist_in    = dist_ff;
      lh_in      = lh_ff;
      tstep_in   = tstep_ff;
      fog_den_in = fog_den_ff;
      wfrac_in   = wfrac_ff;
      fog_in     = fog_ff;
      ty_in      = ty_ff;
      top_in     = top_ff;
      bot_in     = bot_ff;
      o_tex_in   = o_tex_ff;
      o_side_in  = o_side_ff;
      o_dist_in  = o_dist_ff;
      o_top_in   = o_top_ff;
      o_bot_in   = o_bot_ff;
      o_txc_in   = o_txc_ff;
      o_ty_in    = o_ty_ff;
      o_step_in  = o_step_ff;
      o_fog_in   = o_fog_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      q_pop      = 1'b0;
      mem_we     = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = '0;

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_entry.op == OP_CAST) begin
                  col_in   = q_entry.column;
                  state_in = S_CAM;
               end else begin
                  mem_we = 1'b1;
               end
            end
         end
         S_CAM: begin
            // Camera coordinate by reciprocal multiplication.
            cam_in   = $signed({1'b0, cam_prod[36:20]} - 18'h10000);
            state_in = S_RAY_X;
         end
         S_RAY_X: begin
            rdx_in   = $signed({{2{cfg.view_dir_x[17]}}, cfg.view_dir_x} + plane_prod[35:16]);
            state_in = S_RAY_Y;
         end
         S_RAY_Y: begin
            rdy_in   = $signed({{2{cfg.view_dir_y[17]}}, cfg.view_dir_y} + plane_prod[35:16]);
            state_in = S_DDX_GO;
         end
         S_DDX_GO: begin
            if (abs_x == 19'd0) begin
               ddx_in   = {1'b1, 40'b0};
               state_in = S_DDY_GO;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = {1'b1, 32'b0};
               div_req.divisor  = DIV_DEN_W'(abs_x);
               state_in = S_DDX_WAIT;
            end
         end
         S_DDX_WAIT: begin
            if (div_rsp.done) begin
               ddx_in   = {8'b0, div_rsp.quotient};
               state_in = S_DDY_GO;
            end
         end
         S_DDY_GO: begin
            if (abs_y == 19'd0) begin
               ddy_in   = {1'b1, 40'b0};
               state_in = S_SIDE;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = {1'b1, 32'b0};
               div_req.divisor  = DIV_DEN_W'(abs_y);
               state_in = S_DDY_WAIT;
            end
         end
         S_DDY_WAIT: begin
            if (div_rsp.done) begin
               ddy_in   = {8'b0, div_rsp.quotient};
               state_in = S_SIDE;
            end
         end
         S_SIDE: begin
            sdx_in   = side_init(frac_x, ddx_ff);
            sdy_in   = side_init(frac_y, ddy_ff);
            mx_in    = $signed({2'b0, cfg.pos_x[20:16]});
            my_in    = $signed({2'b0, cfg.pos_y[20:16]});
            exit_in  = 1'b0;
            side_in  = 1'b0;
            state_in = S_WALK;
         end
         S_WALK: begin
            // The read of the new cell is issued on this edge.
            if (x_first) begin
               sdx_in  = sdx_ff + {7'b0, ddx_ff};
               side_in = 1'b0;
            end else begin
               sdy_in  = sdy_ff + {7'b0, ddy_ff};
               side_in = 1'b1;
            end
            mx_in    = leave ? 7'sd0 : nmx;
            my_in    = leave ? 7'sd0 : nmy;
            exit_in  = leave;
            state_in = S_READ;
         end
         S_READ: begin
            if (exit_ff || (rdata_ff != 3'd0)) begin
               code_in  = rdata_ff;
               state_in = S_DIST;
            end else begin
               state_in = S_WALK;
            end
         end
         S_DIST: begin
            if (dist_raw < 48'(DIST_MIN)) begin
               dist_in = DIST_MIN;
            end else if (dist_raw > 48'(DIST_MAX)) begin
               dist_in = DIST_MAX;
            end else begin
               dist_in = dist_raw[23:0];
            end
            state_in = S_LH_GO;
         end
         S_LH_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_NUM_W'(SCREEN_HEIGHT) << 16;
            div_req.divisor  = DIV_DEN_W'(dist_ff);
            fog_den_in = 23'h10000 + 23'(fog_prod[37:16]);
            wfrac_in   = (side_ff ? cfg.pos_x[15:0] : cfg.pos_y[15:0]) + wprod[31:16];
            state_in   = S_LH_WAIT;
         end
         S_LH_WAIT: begin
            if (div_rsp.done) begin
               lh_in    = div_rsp.quotient[14:0];
               state_in = S_TSTEP_GO;
            end
         end
         S_TSTEP_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_NUM_W'(TEXTURE_SIZE) << 16;
            div_req.divisor  = (lh_ff == 15'd0) ? DIV_DEN_W'(1) : DIV_DEN_W'(lh_ff);
            state_in = S_TSTEP_WAIT;
         end
         S_TSTEP_WAIT: begin
            if (div_rsp.done) begin
               tstep_in = div_rsp.quotient[24:0];
               state_in = S_TEXROW;
            end
         end
         S_TEXROW: begin
            // Clip the slice to the screen; a clipped top starts lower in the texture.
            if (half_lh > 16'(HALF_H)) begin
               top_in = 7'd0;
               ty_in  = ty_prod[21:0];
            end else begin
               top_in = 7'(16'(HALF_H) - half_lh);
               ty_in  = 22'd0;
            end
            bot_in   = (bsum > 16'(SCREEN_HEIGHT)) ? 8'(SCREEN_HEIGHT) : bsum[7:0];
            state_in = S_FOG_GO;
         end
         S_FOG_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_NUM_W'(256) << 16;
            div_req.divisor  = DIV_DEN_W'(fog_den_ff);
            state_in = S_FOG_WAIT;
         end
         S_FOG_WAIT: begin
            if (div_rsp.done) begin
               fog_in   = div_rsp.quotient[8:0];
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               o_tex_in  = 2'(code_ff - 3'd1);
               o_side_in = side_ff;
               o_dist_in = dist_ff;
               o_top_in  = top_ff;
               o_bot_in  = bot_ff;
               o_txc_in  = mirror ? 6'(TEXTURE_SIZE - 1) - tx_raw : tx_raw;
               o_ty_in   = ty_ff;
               o_step_in = 23'(tstep_ff);
               o_fog_in  = side_ff ? 9'(fog3 >> 2) : fog_ff;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      col_ff     <= col_in;
      cam_ff     <= cam_in;
      rdx_ff     <= rdx_in;
      rdy_ff     <= rdy_in;
      ddx_ff     <= ddx_in;
      ddy_ff     <= ddy_in;
      sdx_ff     <= sdx_in;
      sdy_ff     <= sdy_in;
      mx_ff      <= mx_in;
      my_ff      <= my_in;
      side_ff    <= side_in;
      exit_ff    <= exit_in;
      code_ff    <= code_in;
      dist_ff    <= dist_in;
      lh_ff      <= lh_in;
      tstep_ff   <= tstep_in;
      fog_den_ff <= fog_den_in;
      wfrac_ff   <= wfrac_in;
      fog_ff     <= fog_in;
      ty_ff      <= ty_in;
      top_ff     <= top_in;
      bot_ff     <= bot_in;
      o_tex_ff   <= o_tex_in;
      o_side_ff  <= o_side_in;
      o_dist_ff  <= o_dist_in;
      o_top_ff   <= o_top_in;
      o_bot_ff   <= o_bot_in;
      o_txc_ff   <= o_txc_in;
      o_ty_ff    <= o_ty_in;
      o_step_ff  <= o_step_in;
      o_fog_ff   <= o_fog_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.wall_texture  = o_tex_ff;
   assign rsp_bus.hit_side      = o_side_ff;
   assign rsp_bus.wall_distance = o_dist_ff;
   assign rsp_bus.wall_top      = o_top_ff;
   assign rsp_bus.wall_bottom   = o_bot_ff;
   assign rsp_bus.tex_column    = o_txc_ff;
   assign rsp_bus.tex_row_start = o_ty_ff;
   assign rsp_bus.tex_row_step  = o_step_ff;
   assign rsp_bus.fog_factor    = o_fog_ff;

endmodule

// ----- rtl/grid_raycast_wall_column_top.sv -----
// A map write request is stored by the back end and returns nothing; a
// cast request returns one result. Five divisions per cast (two step
// lengths, line height, texture step and fog) go through a single
// bit-serial divider; a zero ray component skips its step-length division.
// The camera coordinate comes from a reciprocal multiplication, and each
// visited cell costs a step and a registered map read. A two-entry queue
// and an output register let requests arrive while a cast runs and let a
// result wait while the next request is processed. The map store has no
// reset; cells must be written before a ray can reach them.
// ============================================================================
// Grid ray-cast wall column: top level
// Configuration registers, front end, divider and back end.
// ============================================================================
module grid_raycast_wall_column_top #(
   parameter int MAP_DIM       = 32,
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 200,
   parameter int TEXTURE_SIZE  = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   grc_req_if.sink                            req_bus,
   grc_rsp_if.source                          rsp_bus,
   input  logic                               csr_wr_en,
   input  logic [grc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [grc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import grc_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   logic        q_valid;
   entry_type   q_entry;
   logic        q_pop;
   div_req_type div_req;
   div_rsp_type div_rsp;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_POS_X:       cfg_in.pos_x       = csr_wdata;
            CSR_POS_Y:       cfg_in.pos_y       = csr_wdata;
            CSR_VIEW_DIR_X:  cfg_in.view_dir_x  = csr_wdata[17:0];
            CSR_VIEW_DIR_Y:  cfg_in.view_dir_y  = csr_wdata[17:0];
            CSR_CAM_PLANE_X: cfg_in.cam_plane_x = csr_wdata[17:0];
            CSR_CAM_PLANE_Y: cfg_in.cam_plane_y = csr_wdata[17:0];
            CSR_GRID_SIZE:   cfg_in.grid_size   = csr_wdata[4:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pos_x       <= 21'd98304;
         cfg_ff.pos_y       <= 21'd98304;
         cfg_ff.view_dir_x  <= 18'd65536;
         cfg_ff.view_dir_y  <= 18'd0;
         cfg_ff.cam_plane_x <= 18'd0;
         cfg_ff.cam_plane_y <= 18'd43254;
         cfg_ff.grid_size   <= 5'd11;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   grc_front #(
      .MAP_DIM      (MAP_DIM),
      .SCREEN_WIDTH (SCREEN_WIDTH)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_valid (q_valid),
      .q_entry (q_entry),
      .q_pop   (q_pop)
   );

   grc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   grc_back #(
      .MAP_DIM       (MAP_DIM),
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .TEXTURE_SIZE  (TEXTURE_SIZE)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_entry (q_entry),
      .q_pop   (q_pop),
      .cfg     (cfg_ff),
      .div_req (div_req),
      .div_rsp (div_rsp),
      .rsp_bus (rsp_bus)
   );

endmodule
